// ===== sv/lss_pkg.sv =====
// Shared constants and controller/datapath handshake types for the
// longest-run-with-bounded-sum block. No dependencies.
`default_nettype none

package lss_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;  // default sequence capacity
    localparam int VALUE_W          = 16;    // input element width
    localparam int SUM_W            = 32;    // prefix sum, store and limit width
    localparam int BEST_W           = 11;    // result length width

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // take the element, update sums, start the search
        logic seek;    // one search probe
        logic finish;  // fold the candidate into the best length, emit on last
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;      // capacity reached, elements are dropped
        logic seek_end;  // search interval empties after this probe
    } t_status;

endpackage

`default_nettype wire

// ===== sv/longest_subarray_sum_at_most_core.sv =====
// Top level: longest contiguous run with sum at most a programmable limit.
// Depends on lss_pkg, lss_ctrl, lss_dpath (which holds lss_ram).
//
//  Channel    Direction  Signals                     Transaction
//  --------   ---------  --------------------------  ------------------------------
//  element    in         start, busy, i_value,       start high while busy low
//                        i_last
//  result     out        o_done, o_best_length       o_done high for one cycle
//  config     in         i_cfg_we, i_cfg_wdata       i_cfg_we high at a clock edge
//
//  An element is accepted, then takes P binary-search probes over the stored
//  prefix maxima (one RAM read per cycle), then is finished; busy stays high
//  until then. P is at most ceil(log2(n + 2)) for the n-th element.
//  Elements past MAX_ELEMENTS are dropped and skip the probes.
//  The result strobe of a last element rises on the same edge that drops busy.
//  Synchronous active-low reset clears the limit, sums, counters and the
//  strobe; the store needs no clearing pass. The receiver cannot stall.
`default_nettype none

module longest_subarray_sum_at_most_core #(
    parameter int MAX_ELEMENTS = lss_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // element transaction
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [lss_pkg::VALUE_W-1:0] i_value,
    input  wire logic                        i_last,
    // limit register write
    input  wire logic                        i_cfg_we,
    input  wire logic [lss_pkg::SUM_W-1:0]   i_cfg_wdata,
    // result transaction
    output logic                             o_done,
    output logic [lss_pkg::BEST_W-1:0]       o_best_length
);

    lss_pkg::t_cmd    cmd;
    lss_pkg::t_status status;

    // Sequence the element: accept, probe until the interval empties (dropped elements skip it), finish
    lss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    // Hold sums, store, search bounds and the best length; drive the result
    lss_dpath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_value       (i_value),
        .i_last        (i_last),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_done        (o_done),
        .o_best_length (o_best_length)
    );

endmodule

`default_nettype wire

// ===== sv/lss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1025
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/lss_ctrl.sv =====
// Sequencing state machine: accept, search probes, finish.
// Depends on lss_pkg for the command and status types.
`default_nettype none

module lss_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire lss_pkg::t_status i_status,
    output logic                 o_busy,
    output lss_pkg::t_cmd        o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEEK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    // dropped elements skip the search
                    n_state = i_status.full ? S_DONE : S_SEEK;
                end
            end
            S_SEEK: begin
                o_cmd.seek = 1'b1;
                if (i_status.seek_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/lss_dpath.sv =====
// Datapath: limit register, prefix sum, running-maximum store and the
// binary search unit. Depends on lss_pkg and lss_ram.
`default_nettype none

module lss_dpath #(
    parameter int MAX_ELEMENTS = lss_pkg::MAX_ELEMENTS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [lss_pkg::SUM_W-1:0]   i_cfg_wdata,
    input  wire logic [lss_pkg::VALUE_W-1:0] i_value,
    input  wire logic                        i_last,
    input  wire lss_pkg::t_cmd               i_cmd,
    output lss_pkg::t_status                 o_status,
    output logic                             o_done,
    output logic [lss_pkg::BEST_W-1:0]       o_best_length
);

    localparam int CW = $clog2(MAX_ELEMENTS + 2);  // counts up to MAX_ELEMENTS + 1
    localparam int AW = $clog2(MAX_ELEMENTS + 1);  // store address
    localparam int SW = lss_pkg::SUM_W;
    localparam int VW = lss_pkg::VALUE_W;
    localparam int OW = lss_pkg::BEST_W;
    localparam int TW = SW + 2;                    // search target, no wrap

    // control state
    logic signed [SW-1:0] r_limit;
    logic signed [SW-1:0] r_prefix;
    logic signed [SW-1:0] r_run_max;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_best;
    logic                 r_done;
    // payload
    logic [OW-1:0]        r_best_out;
    logic signed [TW-1:0] r_target;
    logic                 r_last;
    logic                 r_use;
    logic [CW-1:0]        r_lo;
    logic [CW-1:0]        r_hi;
    logic [CW-1:0]        r_mid;

    logic [CW-1:0]        pos;
    logic                 full;
    logic signed [SW-1:0] n_prefix;
    logic signed [SW-1:0] n_run;
    logic signed [TW-1:0] n_target;
    logic [SW-1:0]        ram_rdata;
    logic signed [SW-1:0] probe;
    logic signed [TW-1:0] probe_x;
    logic                 ge;
    logic [CW-1:0]        n_lo;
    logic [CW-1:0]        n_hi;
    logic [CW-1:0]        n_mid;
    logic [CW-1:0]        cand_len;
    logic                 cand_ok;
    logic [CW-1:0]        n_best;

    assign pos  = r_count + CW'(1);
    assign full = (r_count == CW'(MAX_ELEMENTS));

    assign n_prefix = r_prefix + {{(SW-VW){i_value[VW-1]}}, i_value};
    assign n_run    = (n_prefix > r_run_max) ? n_prefix : r_run_max;
    assign n_target = {{2{n_prefix[SW-1]}}, n_prefix} - {{2{r_limit[SW-1]}}, r_limit};

    // Entry 0 is zero and entry pos is the running max just written;
    // bypass both so the RAM is never read at a fresh or unwritten slot.
    always_comb begin
        if (r_mid == '0) begin
            probe = '0;
        end else if (r_mid == pos) begin
            probe = r_run_max;
        end else begin
            probe = $signed(ram_rdata);
        end
    end

    assign probe_x = {{2{probe[SW-1]}}, probe};
    assign ge      = (probe_x >= r_target);

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_cmd.load) begin
            n_lo = '0;
            n_hi = r_count + CW'(2);
        end else if (i_cmd.seek) begin
            if (ge) begin
                n_hi = r_mid;
            end else begin
                n_lo = r_mid + CW'(1);
            end
        end
    end

    assign n_mid = n_lo + ((n_hi - n_lo) >> 1);

    assign o_status.full     = full;
    assign o_status.seek_end = !(n_lo < n_hi);

    assign cand_ok  = r_use && (r_lo <= pos);
    assign cand_len = pos - r_lo;
    assign n_best   = (cand_ok && (cand_len > r_best)) ? cand_len : r_best;

    lss_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_ELEMENTS + 1)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && !full),
        .i_waddr (pos[AW-1:0]),
        .i_wdata (n_run),
        .i_raddr (n_mid[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= '0;
            r_prefix  <= '0;
            r_run_max <= '0;
            r_count   <= '0;
            r_best    <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.finish && r_last;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.finish && r_last) begin
                r_prefix  <= '0;
                r_run_max <= '0;
                r_count   <= '0;
                r_best    <= '0;
            end else if (i_cmd.finish) begin
                if (r_use) begin
                    r_count <= pos;
                    r_best  <= n_best;
                end
            end else if (i_cmd.load && !full) begin
                r_prefix  <= n_prefix;
                r_run_max <= n_run;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last   <= i_last;
            r_use    <= !full;
            r_target <= n_target;
        end
        if (i_cmd.finish && r_last) begin
            r_best_out <= OW'(n_best);
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
    end

    assign o_done        = r_done;
    assign o_best_length = r_best_out;

    a_seek_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seek |-> (r_lo < r_hi))
        else $error("search probe on an empty interval");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.seek |-> (r_mid <= pos))
        else $error("search probe beyond the written part of the store");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(i_cmd.finish) && $past(r_last)))
        else $error("result strobe without a finished last element");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ELEMENTS))
        else $error("element count above capacity");

endmodule

`default_nettype wire

// ===== bench/longest_subarray_sum_at_most_core_tb.sv =====
// Self-checking bench for longest_subarray_sum_at_most_core: streams signed
// element sequences, predicts each best run length and compares every result.
// Depends on lss_pkg and the block's top level.
`timescale 1ns / 100ps

module longest_subarray_sum_at_most_core_tb;

    localparam int CAPACITY      = lss_pkg::MAX_ELEMENTS_DEF;
    localparam int GAP_MAX       = 17;    // longest pause drawn before an element
    localparam int SETTLE_CYCLES = 16;    // worst element time plus result delay
    localparam int STALL_LIMIT   = 1000;  // cycles without any transaction
    localparam int ITEMS_TARGET  = 1900;  // element count to reach before random runs stop

    localparam logic [lss_pkg::SUM_W-1:0] LIMIT_MIN = 32'h8000_0000;
    localparam logic [lss_pkg::SUM_W-1:0] LIMIT_MAX = 32'h7FFF_FFFF;

    // Stimulus side, every input known from time zero
    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         start       = 1'b0;
    logic [lss_pkg::VALUE_W-1:0]  i_value     = '0;
    logic                         i_last      = 1'b0;
    logic                         i_cfg_we    = 1'b0;
    logic [lss_pkg::SUM_W-1:0]    i_cfg_wdata = '0;

    logic                         busy;
    logic                         o_done;
    logic [lss_pkg::BEST_W-1:0]   o_best_length;

    // Predicted block state: limit register and the per-sequence scan
    logic signed [lss_pkg::SUM_W-1:0] run_limit = '0;
    longint                  prefix_total;
    longint                  prefix_peak [0:CAPACITY];
    int                      taken_count;
    int                      best_run;

    // Pending best lengths, oldest first
    logic [lss_pkg::BEST_W-1:0] best_length_q [$];
    logic [lss_pkg::BEST_W-1:0] expected_length;

    int  error_count  = 0;
    int  sent_count   = 0;
    int  stall_cycles = 0;
    bit  steady       = 1'b0;  // when set, send elements back to back

    longest_subarray_sum_at_most_core #(
        .MAX_ELEMENTS (lss_pkg::MAX_ELEMENTS_DEF)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_value       (i_value),
        .i_last        (i_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_best_length (o_best_length)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Clear the per-sequence scan; the limit survives.
    function automatic void clear_scan();
        prefix_total   = 0;
        prefix_peak[0] = 0;
        taken_count    = 0;
        best_run       = 0;
    endfunction

    // Advance the scan by one accepted element. Elements beyond capacity are
    // dropped but their last flag still closes the sequence.
    function automatic void track_element(input logic [lss_pkg::VALUE_W-1:0] value,
                                          input logic last);
        longint target;
        int     lo;
        int     hi;
        int     mid;
        int     pos;
        if (taken_count < CAPACITY) begin
            pos          = taken_count + 1;
            prefix_total = prefix_total + longint'($signed(value));
            prefix_peak[pos] = (prefix_peak[taken_count] > prefix_total) ?
                               prefix_peak[taken_count] : prefix_total;
            // Form the search target at full width so no compare wraps
            target = prefix_total - longint'(run_limit);
            lo = 0;
            hi = pos + 1;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (prefix_peak[mid] >= target)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            // An empty search leaves lo past pos and gives no candidate
            if (lo <= pos && pos - lo > best_run)
                best_run = pos - lo;
            taken_count = pos;
        end
        if (last) begin
            best_length_q.push_back(best_run[lss_pkg::BEST_W-1:0]);
            clear_scan();
        end
    endfunction

    // Send one element: draw a pause, raise start, hold until an edge with
    // busy low takes the transaction. Leave start high afterwards so a
    // back-to-back element needs no second assignment in the same step.
    task automatic send_element(input logic [lss_pkg::VALUE_W-1:0] value,
                                input logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        i_last  <= last;
        do @(posedge i_clk); while (busy !== 1'b0);
        track_element(value, last);
        sent_count++;
    endtask

    // Drop start, wait for every pending result, then let the block go quiet.
    task automatic settle();
        start <= 1'b0;
        while (best_length_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [lss_pkg::SUM_W-1:0] limit);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        run_limit = limit;
    endtask

    function automatic logic [lss_pkg::VALUE_W-1:0] pick_value(input int mode);
        int t;
        case (mode)
            0: t = $urandom;
            1: t = $urandom_range(0, 40) - 20;
            2: t = $urandom_range(0, 2000) - 500;
            default: begin
                case ($urandom_range(0, 2))
                    0: t = 32'h0000_8000;
                    1: t = 32'h0000_7FFF;
                    default: t = $urandom;
                endcase
            end
        endcase
        return t[lss_pkg::VALUE_W-1:0];
    endfunction

    function automatic logic [lss_pkg::SUM_W-1:0] pick_limit();
        int t;
        case ($urandom_range(0, 4))
            0: t = $urandom_range(0, 80) - 20;
            1: t = 0;
            2: t = $urandom;
            3: t = $urandom_range(0, 1) ? LIMIT_MIN : LIMIT_MAX;
            default: t = $urandom_range(0, 200000) - 1000;
        endcase
        return t;
    endfunction

    // Short sequences at the field extremes, the limit extremes, and searches
    // that come back empty.
    task automatic test_directed();
        write_limit('0);
        send_element(16'h0000, 1'b1);  // zero sum fits a zero limit
        send_element(16'h7FFF, 1'b1);  // nothing fits
        send_element(16'h8000, 1'b1);
        send_element(16'h8000, 1'b0);
        send_element(16'h7FFF, 1'b0);
        send_element(16'h0001, 1'b0);
        send_element(16'hFFFF, 1'b1);
        // Hold the no-gap mode through one sequence
        steady = 1'b1;
        send_element(16'd5, 1'b0);
        send_element(-16'sd5, 1'b0);
        send_element(16'd5, 1'b0);
        send_element(-16'sd5, 1'b1);
        steady = 1'b0;
        // Most negative limit: target exceeds every stored maximum
        write_limit(LIMIT_MIN);
        send_element(16'h8000, 1'b0);
        send_element(16'h8000, 1'b1);
        // Most positive limit: every run qualifies
        write_limit(LIMIT_MAX);
        send_element(16'h7FFF, 1'b0);
        send_element(16'h7FFF, 1'b0);
        send_element(16'h7FFF, 1'b1);
        // Negative limit with sums that fall then rise: some searches return nothing
        write_limit(-32'sd100);
        send_element(-16'sd50, 1'b0);
        send_element(-16'sd60, 1'b0);
        send_element(16'd10, 1'b1);
    endtask

    // Fill the store past capacity so the trailing elements, the last one
    // among them, are dropped; the wide limit drives the result to the capacity.
    task automatic test_capacity();
        int count;
        count = CAPACITY + 3;
        write_limit(LIMIT_MAX);
        for (int k = 0; k < count; k++)
            send_element(pick_value(0), k == count - 1);
        // Check the state was cleared for the next sequence
        send_element(16'd1, 1'b1);
    endtask

    // Random sequences, mostly short, with the limit changed between groups.
    task automatic test_random_runs();
        int seq_index;
        int seq_len;
        int mode;
        seq_index = 0;
        while (sent_count < ITEMS_TARGET) begin
            if (seq_index % 6 == 0)
                write_limit(pick_limit());
            steady  = ($urandom_range(0, 3) == 0);
            seq_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
            mode    = $urandom_range(0, 3);
            for (int k = 0; k < seq_len; k++)
                send_element(pick_value(mode), k == seq_len - 1);
            seq_index++;
        end
        steady = 1'b0;
    endtask

    // Compare each strobed result with the oldest pending length.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (best_length_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual best_length %0d",
                         $time, o_best_length);
                error_count++;
            end else begin
                expected_length = best_length_q.pop_front();
                if (o_best_length !== expected_length) begin
                    $display("%0t: best_length mismatch, expected %0d, actual %0d",
                             $time, expected_length, o_best_length);
                    error_count++;
                end
            end
        end
    end

    // Abort when no transaction of any kind has happened for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        clear_scan();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_capacity();
        test_random_runs();

        // Drain pending results and let any late strobe show up
        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/lss_pkg.sv
sv/lss_ram.sv
sv/lss_ctrl.sv
sv/lss_dpath.sv
sv/longest_subarray_sum_at_most_core.sv
bench/longest_subarray_sum_at_most_core_tb.sv
